### rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg - shared types and constants for the JSON string unescaper
// Words on both channels, the queue entry, parser phases and status codes.
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam int JSU_QUEUE_DEPTH = 4;

	// status codes carried on the result channel
	localparam logic [2:0] ST_DATA     = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_NO_QUOTE = 3'd2;
	localparam logic [2:0] ST_BAD_ESC  = 3'd3;
	localparam logic [2:0] ST_BAD_HEX  = 3'd4;
	localparam logic [2:0] ST_UNTERM   = 3'd5;
	localparam logic [2:0] ST_SPARE    = 3'd6;

	// UTF-8 encoding constants
	localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
	localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;
	localparam logic [7:0]  LEAD_TWO     = 8'hC0;
	localparam logic [7:0]  LEAD_THREE   = 8'hE0;
	localparam logic [7:0]  CONT_MARK    = 8'h80;
	localparam logic [7:0]  BLANK_MAX    = 8'h20;

	typedef enum logic [2:0] {
		PH_LEAD,
		PH_BODY,
		PH_ESC,
		PH_HEX,
		PH_TRAIL,
		PH_DISCARD
	} phase_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] status;
		logic       last_of_run;
	} result_word_t;

	// one queue entry: up to three result words caused by one text word
	typedef struct packed {
		logic [2:0] status;
		logic [1:0] last_idx;
		logic [7:0] data0;
		logic [7:0] data1;
		logic [7:0] data2;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

### rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front - parser front end
// Takes one text word a cycle while the queue has room, tracks the literal's
// phase and \u digits, and posts a queue entry for each word yielding results.
// ----------------------------------------------------------------------------
module jsu_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               text_valid,
	output logic               text_ready,
	input  jsu_pkg::text_word_t text,
	input  jsu_pkg::fifo_stat_t fstat,
	output logic               push,
	output jsu_pkg::entry_t    push_entry
);
	import jsu_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] acc_q, acc_d;
	logic [1:0]  cnt_q, cnt_d;

	logic        accept;
	logic        is_end;
	logic [7:0]  c;
	logic        is_hex;
	logic [3:0]  hval;
	logic [15:0] cp;
	logic        esc_ok;
	logic [7:0]  esc_val;

	assign text_ready = !fstat.full;
	assign accept     = text_valid && text_ready;
	assign c          = text.text_byte;
	assign is_end     = text.end_of_text || (c == 8'h00);
	assign cp         = {acc_q[11:0], hval};

	always_comb begin
		is_hex = 1'b1;
		hval   = 4'h0;
		if (c >= "0" && c <= "9") begin
			hval = 4'(c - "0");
		end else if (c >= "a" && c <= "f") begin
			hval = 4'(c - "a" + 8'd10);
		end else if (c >= "A" && c <= "F") begin
			hval = 4'(c - "A" + 8'd10);
		end else begin
			is_hex = 1'b0;
		end
	end

	always_comb begin
		esc_ok  = 1'b1;
		esc_val = c;
		case (c)
			"\"", "\\", "/": esc_val = c;
			"b": esc_val = 8'h08;
			"f": esc_val = 8'h0C;
			"n": esc_val = 8'h0A;
			"r": esc_val = 8'h0D;
			"t": esc_val = 8'h09;
			default: esc_ok = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		if (accept) begin
			if (is_end) begin
				phase_d = PH_LEAD;
				acc_d   = '0;
				cnt_d   = '0;
			end else begin
				case (phase_q)
					PH_LEAD: begin
						if (c == "\"") phase_d = PH_BODY;
						else if (c > BLANK_MAX) phase_d = PH_DISCARD;
					end
					PH_BODY: begin
						if (c == "\"") phase_d = PH_TRAIL;
						else if (c == "\\") phase_d = PH_ESC;
					end
					PH_ESC: begin
						if (c == "u") begin
							phase_d = PH_HEX;
							acc_d   = '0;
							cnt_d   = '0;
						end else if (esc_ok) begin
							phase_d = PH_BODY;
						end else begin
							phase_d = PH_DISCARD;
						end
					end
					PH_HEX: begin
						if (!is_hex) begin
							phase_d = PH_DISCARD;
						end else if (cnt_q != 2'd3) begin
							acc_d = cp;
							cnt_d = cnt_q + 2'd1;
						end else begin
							acc_d   = '0;
							cnt_d   = '0;
							phase_d = PH_BODY;
						end
					end
					PH_TRAIL: begin
						if (c > BLANK_MAX) phase_d = PH_DISCARD;
					end
					default: phase_d = PH_DISCARD;
				endcase
			end
		end
	end

	// outputs: queue entry for this word
	always_comb begin
		push       = 1'b0;
		push_entry = '{status: ST_DATA, last_idx: 2'd0, data0: 8'h00, data1: 8'h00,
			data2: 8'h00};
		if (accept) begin
			if (is_end) begin
				push = 1'b1;
				case (phase_q)
					PH_LEAD:  push_entry.status = ST_NO_QUOTE;
					PH_BODY:  push_entry.status = ST_UNTERM;
					PH_ESC:   push_entry.status = ST_BAD_ESC;
					PH_HEX:   push_entry.status = ST_BAD_HEX;
					PH_TRAIL: push_entry.status = ST_DONE;
					default:  push = 1'b0;
				endcase
			end else begin
				case (phase_q)
					PH_LEAD: begin
						if (c != "\"" && c > BLANK_MAX) begin
							push              = 1'b1;
							push_entry.status = ST_NO_QUOTE;
						end
					end
					PH_BODY: begin
						if (c != "\"" && c != "\\") begin
							push             = 1'b1;
							push_entry.data0 = c;
						end
					end
					PH_ESC: begin
						if (esc_ok) begin
							push             = 1'b1;
							push_entry.data0 = esc_val;
						end else if (c != "u") begin
							push              = 1'b1;
							push_entry.status = ST_BAD_ESC;
						end
					end
					PH_HEX: begin
						if (!is_hex) begin
							push              = 1'b1;
							push_entry.status = ST_BAD_HEX;
						end else if (cnt_q == 2'd3) begin
							push = 1'b1;
							if (cp < CP_ONE_LIMIT) begin
								push_entry.data0 = cp[7:0];
							end else if (cp < CP_TWO_LIMIT) begin
								push_entry.last_idx = 2'd1;
								push_entry.data0    = LEAD_TWO | {3'b000, cp[10:6]};
								push_entry.data1    = CONT_MARK | {2'b00, cp[5:0]};
							end else begin
								push_entry.last_idx = 2'd2;
								push_entry.data0    = LEAD_THREE | {4'h0, cp[15:12]};
								push_entry.data1    = CONT_MARK | {2'b00, cp[11:6]};
								push_entry.data2    = CONT_MARK | {2'b00, cp[5:0]};
							end
						end
					end
					PH_TRAIL: begin
						if (c > BLANK_MAX) begin
							push              = 1'b1;
							push_entry.status = ST_SPARE;
						end
					end
					default: push = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			acc_q   <= '0;
			cnt_q   <= '0;
		end else begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

### rtl/jsu_fifo.sv
// ----------------------------------------------------------------------------
// jsu_fifo - entry queue between parser and emitter
// Small circular buffer; head entry is visible while not empty.
// ----------------------------------------------------------------------------
module jsu_fifo #(
	parameter int DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  jsu_pkg::entry_t     push_entry,
	input  logic                pop,
	output jsu_pkg::entry_t     head,
	output jsu_pkg::fifo_stat_t fstat
);
	import jsu_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             ent_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head        = ent_q[rd_ptr_q];
	assign fstat.full  = (cnt_q == CNT_W'(DEPTH));
	assign fstat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back - result emitter
// Steps head entry one word a cycle into the output register as ready allows.
// ----------------------------------------------------------------------------
module jsu_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  jsu_pkg::entry_t       head,
	input  jsu_pkg::fifo_stat_t   fstat,
	output logic                  pop,
	output logic                  result_valid,
	input  logic                  result_ready,
	output jsu_pkg::result_word_t result
);
	import jsu_pkg::*;

	logic [1:0]   idx_q;
	logic         valid_q;
	result_word_t result_q;
	logic         load;
	logic         is_last;
	logic [7:0]   sel_byte;

	assign load    = !fstat.empty && (!valid_q || result_ready);
	assign is_last = (idx_q == head.last_idx);
	assign pop     = load && is_last;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.data0;
			2'd1:    sel_byte = head.data1;
			default: sel_byte = head.data2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= '{out_byte: sel_byte, status: head.status, last_of_run: is_last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (result_ready) begin
				// drop the word once taken
				valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

endmodule

### rtl/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8 - JSON string literal to UTF-8 byte stream
// Parser front end, entry queue and result emitter.
// ----------------------------------------------------------------------------
//	channel   direction  handshake                    word
//	text      in         text_valid / text_ready      text_word_t
//	result    out        result_valid / result_ready  result_word_t
//
// A text word is taken every cycle while the queue has room; the parser
// keeps its phase and \u digits in registers and posts one entry per word
// that yields results. The emitter sends one result word a cycle while
// result_ready allows, so a \u escape giving three bytes holds it for three
// result words; the queue of QUEUE_DEPTH entries absorbs such bursts.
// Reset clears the phase, queue pointers and output valid.
module json_string_unescape_utf8 #(
	parameter int QUEUE_DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  text_valid,
	output logic                  text_ready,
	input  jsu_pkg::text_word_t   text,
	output logic                  result_valid,
	input  logic                  result_ready,
	output jsu_pkg::result_word_t result
);
	import jsu_pkg::*;

	logic       push;
	entry_t     push_entry;
	logic       pop;
	entry_t     head;
	fifo_stat_t fstat;

	jsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text       (text),
		.fstat      (fstat),
		.push       (push),
		.push_entry (push_entry)
	);

	jsu_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.fstat      (fstat)
	);

	jsu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.fstat        (fstat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

### dv/json_string_unescape_utf8_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_tb - regression bench for the JSON string unescaper
// A directed walk through blanks, escapes, \u codes and every error path,
// then random literals (mostly well-formed, some broken, some noise) with
// random idling on both channels. Every accepted text word is decoded by a
// predictor in the bench and each result word is checked against it in order.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_tb;

	import jsu_pkg::*;

	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam int         LIVE_WORDS = 120;
	localparam int         TAIL_CYCLES = 20;
	localparam int         CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
		logic       typed;
		logic [2:0] status;
	} seed_row_t;

	typedef struct {
		text_word_t   word;
		logic         typed;
		result_word_t want;
		logic         drain;
	} plan_row_t;

	// typed rows expect one status word with a zero byte
	localparam seed_row_t DIRECTED [30] = '{
		'{8'h00, 1'b1, 1'b1, ST_NO_QUOTE},
		'{8'h20, 1'b0, 1'b0, ST_DATA},
		'{CH_QUOTE, 1'b0, 1'b0, ST_DATA},
		'{8'hFF, 1'b0, 1'b0, ST_DATA},
		'{CH_BSLASH, 1'b0, 1'b0, ST_DATA},
		'{"u", 1'b0, 1'b0, ST_DATA},
		'{"0", 1'b0, 1'b0, ST_DATA},
		'{"0", 1'b0, 1'b0, ST_DATA},
		'{"0", 1'b0, 1'b0, ST_DATA},
		'{"0", 1'b0, 1'b0, ST_DATA},
		'{CH_QUOTE, 1'b0, 1'b0, ST_DATA},
		'{8'h01, 1'b0, 1'b0, ST_DATA},
		'{8'h00, 1'b0, 1'b1, ST_DONE},
		'{"q", 1'b0, 1'b1, ST_NO_QUOTE},
		'{CH_QUOTE, 1'b0, 1'b0, ST_DATA},
		'{8'hFF, 1'b1, 1'b0, ST_DATA},
		'{CH_QUOTE, 1'b0, 1'b0, ST_DATA},
		'{CH_BSLASH, 1'b0, 1'b0, ST_DATA},
		'{8'h00, 1'b1, 1'b1, ST_BAD_ESC},
		'{CH_QUOTE, 1'b0, 1'b0, ST_DATA},
		'{CH_BSLASH, 1'b0, 1'b0, ST_DATA},
		'{"u", 1'b0, 1'b0, ST_DATA},
		'{"7", 1'b0, 1'b0, ST_DATA},
		'{8'hFF, 1'b1, 1'b1, ST_BAD_HEX},
		'{CH_QUOTE, 1'b0, 1'b0, ST_DATA},
		'{CH_QUOTE, 1'b0, 1'b0, ST_DATA},
		'{"}", 1'b0, 1'b1, ST_SPARE},
		'{8'h00, 1'b1, 1'b0, ST_DATA},
		'{CH_QUOTE, 1'b0, 1'b0, ST_DATA},
		'{8'h00, 1'b1, 1'b1, ST_UNTERM}
	};

	localparam logic [7:0] SIMPLE_ESC [8] = '{CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"};
	localparam logic [15:0] EDGE_CODES [7] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
		16'h0800, 16'hD800, 16'hFFFF};

	logic         clk;
	logic         arst_n;
	logic         text_valid;
	logic         text_ready;
	text_word_t   text;
	logic         result_valid;
	logic         result_ready;
	result_word_t result;

	// predictor state
	phase_t      lit_phase = PH_LEAD;
	logic [15:0] code_acc = '0;
	logic [1:0]  digit_cnt = '0;
	result_word_t burst [3];
	int          burst_n;

	plan_row_t    plan [$];
	result_word_t pending_results [$];
	logic         drain_next = 1'b0;
	int           live_words = 0;
	int           taken = 0;
	int           mismatches = 0;
	int           cycle_count = 0;

	json_string_unescape_utf8 i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_ready   (text_ready),
		.text         (text),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic void post(input logic [7:0] b, input logic [2:0] st);
		burst[burst_n] = '{out_byte: b, status: st, last_of_run: 1'b0};
		burst_n++;
	endfunction

	function automatic void raise_error(input logic [2:0] st);
		post(8'h00, st);
		lit_phase = PH_DISCARD;
	endfunction

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	// decode one text word into burst[0..burst_n-1]
	function automatic void decode_text_word(input text_word_t w);
		logic [7:0]  c;
		logic [15:0] cp;
		int          nib;
		phase_t      was;
		c = w.text_byte;
		burst_n = 0;
		if (w.end_of_text || c == 8'h00) begin
			was = lit_phase;
			lit_phase = PH_LEAD;
			code_acc = '0;
			digit_cnt = '0;
			case (was)
				PH_LEAD:  post(8'h00, ST_NO_QUOTE);
				PH_BODY:  post(8'h00, ST_UNTERM);
				PH_ESC:   post(8'h00, ST_BAD_ESC);
				PH_HEX:   post(8'h00, ST_BAD_HEX);
				PH_TRAIL: post(8'h00, ST_DONE);
				default: ;
			endcase
		end else begin
			case (lit_phase)
				PH_LEAD: begin
					if (c > BLANK_MAX) begin
						if (c == CH_QUOTE) lit_phase = PH_BODY;
						else raise_error(ST_NO_QUOTE);
					end
				end
				PH_BODY: begin
					if (c == CH_QUOTE) lit_phase = PH_TRAIL;
					else if (c == CH_BSLASH) lit_phase = PH_ESC;
					else post(c, ST_DATA);
				end
				PH_ESC: begin
					lit_phase = PH_BODY;
					case (c)
						CH_QUOTE, CH_BSLASH, "/": post(c, ST_DATA);
						"b": post(8'h08, ST_DATA);
						"f": post(8'h0C, ST_DATA);
						"n": post(8'h0A, ST_DATA);
						"r": post(8'h0D, ST_DATA);
						"t": post(8'h09, ST_DATA);
						"u": begin
							lit_phase = PH_HEX;
							code_acc = '0;
							digit_cnt = '0;
						end
						default: raise_error(ST_BAD_ESC);
					endcase
				end
				PH_HEX: begin
					nib = hex_nibble(c);
					if (nib < 0) begin
						raise_error(ST_BAD_HEX);
					end else begin
						code_acc = {code_acc[11:0], 4'(nib)};
						if (digit_cnt != 2'd3) begin
							digit_cnt++;
						end else begin
							cp = code_acc;
							code_acc = '0;
							digit_cnt = '0;
							lit_phase = PH_BODY;
							if (cp < CP_ONE_LIMIT) begin
								post(cp[7:0], ST_DATA);
							end else if (cp < CP_TWO_LIMIT) begin
								post(LEAD_TWO | {3'b000, cp[10:6]}, ST_DATA);
								post(CONT_MARK | {2'b00, cp[5:0]}, ST_DATA);
							end else begin
								post(LEAD_THREE | {4'b0000, cp[15:12]}, ST_DATA);
								post(CONT_MARK | {2'b00, cp[11:6]}, ST_DATA);
								post(CONT_MARK | {2'b00, cp[5:0]}, ST_DATA);
							end
						end
					end
				end
				PH_TRAIL: if (c > BLANK_MAX) raise_error(ST_SPARE);
				default: ;
			endcase
		end
		if (burst_n != 0) burst[burst_n - 1].last_of_run = 1'b1;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'("0" + n);
		return 8'(($urandom_range(0, 1) ? "a" : "A") + (n - 4'd10));
	endfunction

	task automatic add_word(input logic [7:0] b, input logic eot, input logic counted);
		plan_row_t row;
		row.word = '{text_byte: b, end_of_text: eot};
		row.typed = 1'b0;
		row.want = '0;
		row.drain = drain_next;
		drain_next = 1'b0;
		plan.push_back(row);
		if (counted) live_words++;
	endtask

	task automatic add_end();
		if ($urandom_range(0, 1)) add_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
		else add_word(8'h00, 1'b0, 1'b1);
	endtask

	// one literal: mostly well-formed, some broken part way, a little noise
	task automatic gen_literal();
		int unsigned mode;
		int unsigned flavour;
		logic [7:0]  b;
		logic [15:0] cp;
		mode = $urandom_range(0, 99);
		if ($urandom_range(0, 24) == 0) drain_next = 1'b1;
		if (mode < 7) begin
			repeat ($urandom_range(1, 6))
				add_word(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, 1'b1);
			add_end();
			return;
		end
		repeat ($urandom_range(0, 2)) add_word(8'($urandom_range(1, 32)), 1'b0, 1'b1);
		add_word(CH_QUOTE, 1'b0, 1'b1);
		repeat ($urandom_range(0, 8)) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
					add_word(b, 1'b0, 1'b1);
				end
				4, 5, 6: begin
					add_word(CH_BSLASH, 1'b0, 1'b1);
					add_word(SIMPLE_ESC[$urandom_range(0, 7)], 1'b0, 1'b1);
				end
				default: begin
					case ($urandom_range(0, 5))
						0: cp = 16'($urandom_range(0, 16'h007F));
						1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
						2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
						3: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
						4: cp = EDGE_CODES[$urandom_range(0, 6)];
						default: cp = 16'($urandom);
					endcase
					add_word(CH_BSLASH, 1'b0, 1'b1);
					add_word("u", 1'b0, 1'b1);
					for (int k = 3; k >= 0; k--) add_word(hex_char(cp[4*k +: 4]), 1'b0, 1'b1);
				end
			endcase
		end
		if (mode < 20) begin
			// break the literal: odd escape, short or bad hex, end inside, spare byte
			flavour = $urandom_range(0, 5);
			case (flavour)
				0: begin
					add_word(CH_BSLASH, 1'b0, 1'b1);
					add_word(8'($urandom_range(1, 255)), 1'b0, 1'b1);
				end
				1, 4: begin
					add_word(CH_BSLASH, 1'b0, 1'b1);
					add_word("u", 1'b0, 1'b1);
					repeat ($urandom_range(0, 3)) add_word(hex_char(4'($urandom)), 1'b0, 1'b1);
					if (flavour == 1) add_word(8'($urandom_range(1, 255)), 1'b0, 1'b1);
				end
				3: add_word(CH_BSLASH, 1'b0, 1'b1);
				5: begin
					add_word(CH_QUOTE, 1'b0, 1'b1);
					add_word(8'($urandom_range(33, 255)), 1'b0, 1'b1);
				end
				default: ;
			endcase
			if (flavour == 0 || flavour == 1 || flavour == 5)
				repeat ($urandom_range(0, 3)) add_word(8'($urandom_range(1, 255)), 1'b0, 1'b0);
			add_end();
			return;
		end
		add_word(CH_QUOTE, 1'b0, 1'b1);
		repeat ($urandom_range(0, 2)) add_word(8'($urandom_range(1, 32)), 1'b0, 1'b1);
		add_end();
	endtask

	// text side
	initial begin
		plan_row_t   row;
		int unsigned gap;
		int unsigned calm;
		calm = 0;
		text_valid <= 1'b0;
		text <= '0;
		foreach (DIRECTED[i]) begin
			row.word = '{text_byte: DIRECTED[i].text_byte, end_of_text: DIRECTED[i].end_of_text};
			row.typed = DIRECTED[i].typed;
			row.want = '{out_byte: 8'h00, status: DIRECTED[i].status, last_of_run: 1'b1};
			row.drain = 1'b0;
			plan.push_back(row);
		end
		drain_next = 1'b1;
		while (live_words < LIVE_WORDS) gen_literal();

		do @(posedge clk); while (!arst_n);
		foreach (plan[i]) begin
			gap = 0;
			if (calm != 0) begin
				calm--;
			end else begin
				if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 40);
				gap = pick_gap();
			end
			if (plan[i].drain && gap == 0) gap = 1;
			if (gap != 0) begin
				text_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				// hold off until every expected word has come back
				if (plan[i].drain) while (pending_results.size() != 0) @(posedge clk);
			end
			text_valid <= 1'b1;
			text <= plan[i].word;
			do @(posedge clk); while (!text_ready);
		end
		text_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("json_string_unescape_utf8 regression: pass");
		else
			$display("json_string_unescape_utf8 regression: fail");
		$finish;
	end

	// result side: runs of ready with stalls of random length
	initial begin
		int unsigned stall;
		result_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			result_ready <= 1'b1;
			if ($urandom_range(0, 9) == 0) repeat ($urandom_range(40, 120)) @(posedge clk);
			else repeat ($urandom_range(1, 12)) @(posedge clk);
			stall = pick_gap();
			if (stall != 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// predict on each accepted text word, then check the result word
	always @(posedge clk) begin
		result_word_t want;
		if (arst_n) begin
			if (text_valid && text_ready) begin
				decode_text_word(text);
				if (plan[taken].typed) begin
					pending_results.push_back(plan[taken].want);
				end else begin
					for (int k = 0; k < burst_n; k++) pending_results.push_back(burst[k]);
				end
				taken++;
			end
			if (result_valid && result_ready) begin
				if (pending_results.size() == 0) begin
					flag_mismatch($sformatf("unexpected word byte %02h status %0d last %0b",
						result.out_byte, result.status, result.last_of_run));
				end else begin
					want = pending_results.pop_front();
					if (result.out_byte !== want.out_byte)
						flag_mismatch($sformatf("out_byte %02h, want %02h (status %0d)",
							result.out_byte, want.out_byte, want.status));
					if (result.status !== want.status)
						flag_mismatch($sformatf("status %0d, want %0d",
							result.status, want.status));
					if (result.last_of_run !== want.last_of_run)
						flag_mismatch($sformatf("last_of_run %0b, want %0b (byte %02h)",
							result.last_of_run, want.last_of_run, want.out_byte));
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("json_string_unescape_utf8 regression: fail");
		$finish;
	end

endmodule
